// ----- hw/rtl/soa_pkg.sv -----
// Shared types and codes for the slab object allocator.
// No dependencies; imported by slab_object_allocator_unit.
package soa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_SHRINK  = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFRAME = 2'd1,
    ST_REJECT  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_EMPTY   = 2'd0,
    K_PARTIAL = 2'd1,
    K_FULL    = 2'd2,
    K_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_POOL_BASE   = 2'd0,
    CFG_SLAB_ORDER  = 2'd1,
    CFG_OBJECT_SIZE = 2'd2,
    CFG_OBJS_PER    = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_A_RD, S_A_LD, S_TAKE, S_LNK, S_MUL, S_ADD, S_SCAN,
    S_F_CHK, S_F_RD, S_F_LD, S_DIV, S_F_END,
    S_SH_CHK, S_SH_RD, S_SH_LD,
    S_REM, S_PUSH, S_FIN, S_WB, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] object_address;
    logic [1:0]  status;
  } out_item_t;

  localparam int unsigned BUSY_W   = 10;
  localparam int unsigned BUSY_MAX = 1023;

endpackage

// ----- hw/rtl/slab_object_allocator_unit.sv -----
// Slab object allocator: sequencer, slab tables, object link memory, divider.
// Depends on soa_pkg.
//
//  channel | ports                              | transfer
//  input   | start, busy, in_data               | start && !busy
//  result  | out_valid, out_data                | out_valid, one cycle
//  config  | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// Alloc reads the record of the first partial slab, else of the first empty one;
// with neither, it scans the frames one at a time for an unused one. Free checks the
// address, reads the slab record and runs the 32-step bit-serial divider; early rejects skip it.
// Shrink reads and unlinks one empty slab at a time; release goes straight to the result.
// Reset and release clear slab tables at once through per-entry valid bits.
// Results cannot be stalled; busy stays high up to and including the result strobe.
module slab_object_allocator_unit #(
  parameter int NUM_SLABS  = 64,
  parameter int MAX_OBJS   = 512,
  parameter int MAX_ORDER  = 10,
  parameter int PAGE_BYTES = 4096,
  parameter int ADDR_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  soa_pkg::in_item_t in_data,
  output logic              out_valid,
  output soa_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import soa_pkg::*;

  localparam int SI    = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int SW    = $clog2(NUM_SLABS + 1);
  localparam int OW    = $clog2(MAX_OBJS + 1);
  localparam int OBW   = $clog2(MAX_OBJS);
  localparam int AW    = ADDR_BITS;
  localparam int SHW   = 6;
  localparam int PB_LG = $clog2(PAGE_BYTES);
  localparam int RECW  = 2 * OW + BUSY_W + 2;
  localparam int LKD   = NUM_SLABS << OBW;
  localparam logic [SW-1:0] NO_SLAB = SW'(NUM_SLABS);
  localparam logic [OW-1:0] NO_OBJ  = OW'(MAX_OBJS);
  localparam logic [RECW-1:0] REC_RST = {NO_OBJ, {OW{1'b0}}, {BUSY_W{1'b0}}, K_UNUSED};

  state_t st_r, st_nxt;
  logic [31:0] base_r;
  logic [3:0]  ord_r;
  logic [22:0] osz_r;
  logic [9:0]  ops_r;

  logic [1:0]  op_r, op_nxt;
  logic [31:0] ain_r, ain_nxt;
  logic [SI-1:0] s_r, s_nxt;
  logic [SI-1:0] scan_r, scan_nxt;
  logic [OW-1:0] fh_r, fh_nxt, fr_r, fr_nxt, obj_r, obj_nxt;
  logic [BUSY_W-1:0] bz_r, bz_nxt;
  kind_t kd_r, kd_nxt, tgt_r, tgt_nxt;
  logic [SW-1:0] pv_r, pv_nxt, nx_r, nx_nxt;
  logic [SW-1:0] heads_r [3], heads_nxt [3];
  logic [SW-1:0] tails_r [3], tails_nxt [3];
  logic [NUM_SLABS-1:0] rvld_r, rvld_nxt, pvld_r, pvld_nxt, nvld_r, nvld_nxt;
  logic [NUM_SLABS-1:0] unused_r, unused_nxt;
  logic [31:0] dq_r, dq_nxt;
  logic [22:0] rem_r, rem_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic [OW+22:0] prod_r, prod_nxt;
  logic [31:0] res_addr_r, res_addr_nxt;
  status_t res_st_r, res_st_nxt;

  logic [RECW-1:0] rec_mem [NUM_SLABS];
  logic [SW-1:0]   prv_mem [NUM_SLABS];
  logic [SW-1:0]   nxt_mem [NUM_SLABS];
  logic [OW-1:0]   lk_mem  [LKD];
  logic [RECW-1:0] rec_q;
  logic [SW-1:0]   pv_q, nx_q;
  logic [OW-1:0]   lk_q;

  logic            rec_we, prv_we, nxt_we, lk_we;
  logic [SI-1:0]   rec_wa, prv_wa, nxt_wa;
  logic [RECW-1:0] rec_wd;
  logic [SW-1:0]   prv_wd, nxt_wd;
  logic [SI+OBW-1:0] lk_wa;
  logic [OW-1:0]   lk_wd;

  logic [SHW-1:0] ord_ext, ordc, sh;
  logic [22:0]    obc;
  logic [OW-1:0]  cnt_w;
  logic [31:0]    off, fq, frm_off;
  logic [23:0]    rem_sh;
  logic           ge;
  logic [SW-1:0]  t_w;
  logic [AW-1:0]  sum_w;

  assign cfg_ready = 1'b1;
  assign busy      = (st_r != S_IDLE);
  assign out_valid = (st_r == S_DONE);
  assign out_data  = '{object_address: res_addr_r, status: res_st_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      ord_r  <= '0;
      osz_r  <= 23'd8;
      ops_r  <= 10'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POOL_BASE:   base_r <= cfg_data;
        CFG_SLAB_ORDER:  ord_r  <= cfg_data[3:0];
        CFG_OBJECT_SIZE: osz_r  <= cfg_data[22:0];
        CFG_OBJS_PER:    ops_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ord_ext = SHW'(ord_r);
    ordc    = (ord_ext > SHW'(MAX_ORDER)) ? SHW'(MAX_ORDER) : ord_ext;
    sh      = SHW'(PB_LG) + ordc;
    obc     = (osz_r == '0) ? 23'd1 : osz_r;
    cnt_w   = (ops_r == '0) ? OW'(1) :
              ((32'(ops_r) > 32'(MAX_OBJS)) ? NO_OBJ : OW'(ops_r));
    off     = ain_r - base_r;
    fq      = off >> sh;
    frm_off = off & ~(32'hFFFF_FFFF << sh);
    rem_sh  = {rem_r, dq_r[31]};
    ge      = rem_sh >= {1'b0, obc};
    t_w     = tails_r[int'(tgt_r)];
    sum_w   = AW'(base_r) + (AW'(s_r) << sh) + AW'(prod_r);
  end

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; ain_nxt = ain_r; s_nxt = s_r; scan_nxt = scan_r;
    fh_nxt = fh_r; fr_nxt = fr_r; obj_nxt = obj_r; bz_nxt = bz_r; kd_nxt = kd_r;
    tgt_nxt = tgt_r; pv_nxt = pv_r; nx_nxt = nx_r;
    heads_nxt = heads_r; tails_nxt = tails_r;
    rvld_nxt = rvld_r; pvld_nxt = pvld_r; nvld_nxt = nvld_r; unused_nxt = unused_r;
    dq_nxt = dq_r; rem_nxt = rem_r; dcnt_nxt = dcnt_r; prod_nxt = prod_r;
    res_addr_nxt = res_addr_r; res_st_nxt = res_st_r;
    rec_we = 1'b0; rec_wa = s_r; rec_wd = {fh_r, fr_r, bz_r, kd_r};
    prv_we = 1'b0; prv_wa = s_r; prv_wd = NO_SLAB;
    nxt_we = 1'b0; nxt_wa = s_r; nxt_wd = NO_SLAB;
    lk_we = 1'b0; lk_wa = {s_r, obj_r[OBW-1:0]}; lk_wd = fh_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_data.operation;
          ain_nxt = in_data.address;
          res_addr_nxt = '0;
          res_st_nxt = ST_DONE;
          unique case (op_t'(in_data.operation))
            OP_ALLOC: begin
              if (heads_r[K_PARTIAL] != NO_SLAB) begin
                s_nxt = SI'(heads_r[K_PARTIAL]);
                st_nxt = S_A_RD;
              end else if (heads_r[K_EMPTY] != NO_SLAB) begin
                s_nxt = SI'(heads_r[K_EMPTY]);
                st_nxt = S_A_RD;
              end else begin
                scan_nxt = '0;
                st_nxt = S_SCAN;
              end
            end
            OP_FREE: st_nxt = S_F_CHK;
            OP_SHRINK: st_nxt = S_SH_CHK;
            OP_RELEASE: begin
              rvld_nxt = '0; pvld_nxt = '0; nvld_nxt = '0; unused_nxt = '1;
              for (int k = 0; k < 3; k++) begin
                heads_nxt[k] = NO_SLAB;
                tails_nxt[k] = NO_SLAB;
              end
              st_nxt = S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_A_RD: st_nxt = S_A_LD;
      S_A_LD: begin
        fh_nxt = rec_q[RECW-1 -: OW];
        fr_nxt = rec_q[RECW-OW-1 -: OW];
        bz_nxt = rec_q[BUSY_W+1:2];
        kd_nxt = kind_t'(rec_q[1:0]);
        pv_nxt = pv_q;
        nx_nxt = nx_q;
        st_nxt = S_TAKE;
      end
      S_SCAN: begin
        if (unused_r[scan_r]) begin
          s_nxt = scan_r;
          unused_nxt[scan_r] = 1'b0;
          fh_nxt = NO_OBJ; fr_nxt = cnt_w; bz_nxt = '0; kd_nxt = K_UNUSED;
          st_nxt = S_TAKE;
        end else if (32'(scan_r) == 32'(NUM_SLABS - 1)) begin
          res_st_nxt = ST_NOFRAME;
          st_nxt = S_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_TAKE: begin
        if (bz_r != BUSY_W'(BUSY_MAX)) bz_nxt = bz_r + 1'b1;
        if (fh_r < NO_OBJ) begin
          obj_nxt = fh_r;
          st_nxt = S_LNK;
        end else if (fr_r != '0) begin
          fr_nxt = fr_r - 1'b1;
          obj_nxt = fr_r - 1'b1;
          st_nxt = S_MUL;
        end else begin
          bz_nxt = bz_r;
          res_st_nxt = ST_NOFRAME;
          st_nxt = S_DONE;
        end
      end
      S_LNK: begin
        fh_nxt = lk_q;
        st_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = obj_r * obc;
        tgt_nxt = (fh_r >= NO_OBJ && fr_r == '0) ? K_FULL : K_PARTIAL;
        st_nxt = S_ADD;
      end
      S_ADD: begin
        res_addr_nxt = 32'(sum_w);
        st_nxt = (kd_r != tgt_r) ? S_REM : S_WB;
      end
      S_F_CHK: begin
        if (ain_r == '0 || ain_r < base_r || fq >= 32'(NUM_SLABS)) begin
          res_st_nxt = ST_REJECT;
          st_nxt = S_DONE;
        end else begin
          s_nxt = SI'(fq);
          dq_nxt = frm_off;
          rem_nxt = '0;
          dcnt_nxt = '0;
          st_nxt = S_F_RD;
        end
      end
      S_F_RD: st_nxt = S_F_LD;
      S_F_LD: begin
        fh_nxt = rec_q[RECW-1 -: OW];
        fr_nxt = rec_q[RECW-OW-1 -: OW];
        bz_nxt = rec_q[BUSY_W+1:2];
        kd_nxt = kind_t'(rec_q[1:0]);
        pv_nxt = pv_q;
        nx_nxt = nx_q;
        if (kind_t'(rec_q[1:0]) == K_UNUSED) begin
          res_st_nxt = ST_REJECT;
          st_nxt = S_DONE;
        end else begin
          st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? 23'(rem_sh - {1'b0, obc}) : rem_sh[22:0];
        dq_nxt = {dq_r[30:0], ge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 5'd31) st_nxt = S_F_END;
      end
      S_F_END: begin
        if (rem_r != '0 || dq_r >= 32'(cnt_w) || bz_r == '0) begin
          res_st_nxt = ST_REJECT;
          st_nxt = S_DONE;
        end else begin
          lk_we = 1'b1;
          lk_wa = {s_r, dq_r[OBW-1:0]};
          lk_wd = fh_r;
          fh_nxt = OW'(dq_r);
          bz_nxt = bz_r - 1'b1;
          tgt_nxt = (bz_r == BUSY_W'(1)) ? K_EMPTY : K_PARTIAL;
          st_nxt = (kd_r != ((bz_r == BUSY_W'(1)) ? K_EMPTY : K_PARTIAL)) ? S_REM : S_WB;
        end
      end
      S_SH_CHK: begin
        if (heads_r[K_EMPTY] != NO_SLAB) begin
          s_nxt = SI'(heads_r[K_EMPTY]);
          st_nxt = S_SH_RD;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_SH_RD: st_nxt = S_SH_LD;
      S_SH_LD: begin
        heads_nxt[K_EMPTY] = nx_q;
        if (nx_q != NO_SLAB) begin
          prv_we = 1'b1;
          prv_wa = SI'(nx_q);
          prv_wd = NO_SLAB;
        end else begin
          tails_nxt[K_EMPTY] = NO_SLAB;
        end
        rvld_nxt[s_r] = 1'b0;
        unused_nxt[s_r] = 1'b1;
        st_nxt = S_SH_CHK;
      end
      S_REM: begin
        if (kd_r != K_UNUSED) begin
          if (pv_r != NO_SLAB) begin
            nxt_we = 1'b1; nxt_wa = SI'(pv_r); nxt_wd = nx_r;
          end else begin
            heads_nxt[int'(kd_r)] = nx_r;
          end
          if (nx_r != NO_SLAB) begin
            prv_we = 1'b1; prv_wa = SI'(nx_r); prv_wd = pv_r;
          end else begin
            tails_nxt[int'(kd_r)] = pv_r;
          end
        end
        st_nxt = S_PUSH;
      end
      S_PUSH: begin
        prv_we = 1'b1; prv_wa = s_r; prv_wd = t_w;
        if (t_w != NO_SLAB) begin
          nxt_we = 1'b1; nxt_wa = SI'(t_w); nxt_wd = SW'(s_r);
        end else begin
          heads_nxt[int'(tgt_r)] = SW'(s_r);
        end
        tails_nxt[int'(tgt_r)] = SW'(s_r);
        st_nxt = S_FIN;
      end
      S_FIN: begin
        nxt_we = 1'b1; nxt_wa = s_r; nxt_wd = NO_SLAB;
        rec_we = 1'b1; rec_wd = {fh_r, fr_r, bz_r, tgt_r};
        st_nxt = S_DONE;
      end
      S_WB: begin
        rec_we = 1'b1;
        st_nxt = S_DONE;
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (rec_we) rvld_nxt[rec_wa] = 1'b1;
    if (prv_we) pvld_nxt[prv_wa] = 1'b1;
    if (nxt_we) nvld_nxt[nxt_wa] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      rvld_r <= '0; pvld_r <= '0; nvld_r <= '0; unused_r <= '1;
      for (int k = 0; k < 3; k++) begin
        heads_r[k] <= NO_SLAB;
        tails_r[k] <= NO_SLAB;
      end
    end else begin
      st_r <= st_nxt;
      rvld_r <= rvld_nxt; pvld_r <= pvld_nxt; nvld_r <= nvld_nxt; unused_r <= unused_nxt;
      heads_r <= heads_nxt;
      tails_r <= tails_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; ain_r <= ain_nxt; s_r <= s_nxt; scan_r <= scan_nxt;
    fh_r <= fh_nxt; fr_r <= fr_nxt; obj_r <= obj_nxt; bz_r <= bz_nxt; kd_r <= kd_nxt;
    tgt_r <= tgt_nxt; pv_r <= pv_nxt; nx_r <= nx_nxt;
    dq_r <= dq_nxt; rem_r <= rem_nxt; dcnt_r <= dcnt_nxt; prod_r <= prod_nxt;
    res_addr_r <= res_addr_nxt; res_st_r <= res_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    rec_q <= rvld_r[s_r] ? rec_mem[s_r] : REC_RST;
    pv_q  <= pvld_r[s_r] ? prv_mem[s_r] : NO_SLAB;
    nx_q  <= nvld_r[s_r] ? nxt_mem[s_r] : NO_SLAB;
    lk_q  <= lk_mem[{s_r, fh_r[OBW-1:0]}];
  end

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("transfer accepted but block not busy");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DONE |-> out_data.object_address == '0)
    else $error("failed request returned an address");
  a_nonalloc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && op_r != OP_ALLOC |-> out_data.object_address == '0)
    else $error("non-alloc request returned an address");
  a_noframe_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NOFRAME |-> op_r == OP_ALLOC)
    else $error("no-frame status on non-alloc request");

endmodule
